[rtl/sbpm_pkg.sv]
// ----------------------------------------------------------------------------
// sbpm_pkg - shared types and constants of the stereo block peak meter
// Sample width, log table, register indexes and inter-module structs.
// ----------------------------------------------------------------------------
package sbpm_pkg;

    localparam int SAMPLE_BITS = 16;              // 8..16 with 16-bit sample fields
    localparam int IN_W        = 16;              // width of a sample field
    localparam int MAG_W       = SAMPLE_BITS;     // magnitude, up to 2^(SAMPLE_BITS-1)
    localparam int E_W         = 5;               // leading-one index
    localparam int NORM_W      = 32;              // normalised word
    localparam int FRAC_W      = 16;
    localparam int SEG_W       = 4;
    localparam int DIFF_W      = 12;
    localparam int PROD_W      = DIFF_W + FRAC_W;
    localparam int LG_W        = 20;              // log in 1/4096 dB
    localparam int LEVEL_W     = 12;
    localparam int RANGE_W     = 8;
    localparam int CHAN_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int FIFO_DEPTH  = 8;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = PTR_W + 1;

    localparam logic [LG_W-1:0] OCTAVE_UNITS = LG_W'(24660);
    localparam logic [LG_W-1:0] ATT_FS       = LG_W'((SAMPLE_BITS - 1) * 24660);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_DB      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = CFG_IDX_W'(1);

    localparam logic [RANGE_W-1:0] RANGE_DB_RST      = RANGE_W'(30);
    localparam logic [CHAN_W-1:0]  CHANNEL_COUNT_RST = CHAN_W'(2);

    // segment base, 1/4096 dB: round(81920*log10(1+k/16))
    localparam logic [14:0] LOG_BASE [16] = '{
        15'd0,     15'd2157,  15'd4190,  15'd6114,
        15'd7939,  15'd9675,  15'd11330, 15'd12911,
        15'd14425, 15'd15878, 15'd17273, 15'd18616,
        15'd19910, 15'd21158, 15'd22364, 15'd23531
    };

    // slope of each segment: next base minus this base
    localparam logic [DIFF_W-1:0] LOG_DIFF [16] = '{
        12'd2157, 12'd2033, 12'd1924, 12'd1825,
        12'd1736, 12'd1655, 12'd1581, 12'd1514,
        12'd1453, 12'd1395, 12'd1343, 12'd1294,
        12'd1248, 12'd1206, 12'd1167, 12'd1129
    };

    typedef struct packed {
        logic vld;   // item accepted
        logic last;  // item closes a block
        logic upd;   // channel active
    } t_lane_ctl;

    typedef struct packed {
        logic               vld;
        logic [LEVEL_W-1:0] level;
    } t_lane_out;

    typedef struct packed {
        logic [LEVEL_W-1:0] right_level;
        logic [LEVEL_W-1:0] left_level;
    } t_result;

endpackage

[rtl/sbpm_lane.sv]
// ----------------------------------------------------------------------------
// sbpm_lane - one channel of the peak meter
// Magnitude, running peak, then a four-stage log/level pipeline.
// ----------------------------------------------------------------------------
module sbpm_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sbpm_pkg::t_lane_ctl           i_ctl,
    input  logic [sbpm_pkg::IN_W-1:0]     i_sample,
    input  logic [sbpm_pkg::RANGE_W-1:0]  i_range_db,
    output sbpm_pkg::t_lane_out           o_out
);
    import sbpm_pkg::*;

    logic [MAG_W-1:0]   v_raw;
    logic [MAG_W-1:0]   v_mag;
    logic [MAG_W-1:0]   v_peak;

    logic               r_a_vld, r_a_last, r_a_upd;
    logic [MAG_W-1:0]   r_a_mag;
    logic [MAG_W-1:0]   r_peak;

    logic               r_b_vld, r_b_upd;
    logic [MAG_W-1:0]   r_b_peak;

    logic [E_W-1:0]     v_e;
    logic [NORM_W-1:0]  v_norm;
    logic               r1_vld, r1_clr;
    logic [E_W-1:0]     r1_e;
    logic [SEG_W-1:0]   r1_k;
    logic [FRAC_W-1:0]  r1_f;

    logic               r2_vld, r2_clr;
    logic [LG_W-1:0]    r2_base;
    logic [PROD_W-1:0]  r2_prod;

    logic [LG_W-1:0]    v_lg;
    logic [LG_W-1:0]    v_att;
    logic [LG_W-1:0]    v_att_rnd;
    logic               r3_vld, r3_clr;
    logic [LEVEL_W-1:0] r3_a16;

    logic [LEVEL_W-1:0] v_top;
    logic               r4_vld;
    logic [LEVEL_W-1:0] r4_level;

    // magnitude; the most negative code maps to full scale by itself
    assign v_raw = i_sample[MAG_W-1:0];
    assign v_mag = v_raw[MAG_W-1] ? MAG_W'(~v_raw + 1'b1) : v_raw;

    assign v_peak = (r_a_upd && (r_a_mag > r_peak)) ? r_a_mag : r_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_peak  <= '0;
        end else begin
            r_a_vld <= i_ctl.vld;
            r_b_vld <= r_a_vld && r_a_last;
            if (r_a_vld) begin
                r_peak <= r_a_last ? '0 : v_peak;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_mag  <= v_mag;
        r_a_last <= i_ctl.last;
        r_a_upd  <= i_ctl.upd;
        r_b_peak <= v_peak;
        r_b_upd  <= r_a_upd;
    end

    // stage 1: leading one and normalise
    always_comb begin
        v_e = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (r_b_peak[i]) v_e = E_W'(i);
        end
    end

    assign v_norm = {{(NORM_W-MAG_W){1'b0}}, r_b_peak} << (E_W'(NORM_W - 1) - v_e);

    always_ff @(posedge i_clk) begin
        r1_e   <= v_e;
        r1_k   <= v_norm[NORM_W-2 -: SEG_W];
        r1_f   <= v_norm[NORM_W-2-SEG_W -: FRAC_W];
        r1_clr <= (r_b_peak == '0) || !r_b_upd;
    end

    // stage 2: octave plus segment base, slope times fraction
    always_ff @(posedge i_clk) begin
        r2_base <= LG_W'(LG_W'(r1_e) * OCTAVE_UNITS) + LG_W'(LOG_BASE[r1_k]);
        r2_prod <= PROD_W'(LOG_DIFF[r1_k]) * PROD_W'(r1_f);
        r2_clr  <= r1_clr;
    end

    // stage 3: attenuation below full scale, rounded to 1/16 dB
    assign v_lg      = r2_base + LG_W'((r2_prod + PROD_W'(32768)) >> FRAC_W);
    assign v_att     = (ATT_FS > v_lg) ? (ATT_FS - v_lg) : '0;
    assign v_att_rnd = v_att + LG_W'(128);

    always_ff @(posedge i_clk) begin
        r3_a16 <= v_att_rnd[8 +: LEVEL_W];
        r3_clr <= r2_clr;
    end

    // stage 4: subtract from the displayed range, floor at zero
    assign v_top = {i_range_db, 4'b0000};

    always_ff @(posedge i_clk) begin
        if (r3_clr || (r3_a16 >= v_top)) begin
            r4_level <= '0;
        end else begin
            r4_level <= v_top - r3_a16;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            r1_vld <= r_b_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    assign o_out.vld   = r4_vld;
    assign o_out.level = r4_level;

endmodule

[rtl/sbpm_merge.sv]
// ----------------------------------------------------------------------------
// sbpm_merge - joins the lane levels into one result item
// Small result queue with a credit count that covers items still in the lanes.
// ----------------------------------------------------------------------------
module sbpm_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,      // block-closing item accepted
    input  sbpm_pkg::t_lane_out           i_left,
    input  sbpm_pkg::t_lane_out           i_right,
    output logic                          o_room,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output sbpm_pkg::t_result             m_axis_tdata
);
    import sbpm_pkg::*;

    t_result            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_fill, r_credit;
    logic               v_pop;

    assign v_pop         = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = (r_fill != '0);
    assign m_axis_tdata  = r_mem[r_rd_ptr];
    assign o_room        = (r_credit < CNT_W'(FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_left.vld) begin
            r_mem[r_wr_ptr] <= '{right_level: i_right.level, left_level: i_left.level};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
            r_credit <= '0;
        end else begin
            if (i_left.vld) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (v_pop)      r_rd_ptr <= r_rd_ptr + 1'b1;
            r_fill   <= r_fill + CNT_W'(i_left.vld) - CNT_W'(v_pop);
            r_credit <= r_credit + CNT_W'(i_take) - CNT_W'(v_pop);
        end
    end

endmodule

[rtl/stereo_block_peak_db_meter.sv]
// ----------------------------------------------------------------------------
// stereo_block_peak_db_meter - per-channel block peak level in 1/16 dB
// Two lanes track channel peaks; at the end of a block each lane turns its
// peak into range_db + 20*log10(peak/full scale), floored at 0.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle, closing items too, while the queue has room.
// Path: a closing item is registered through the input, peak, normalise, multiply,
//   atten and level stages, then queued, before its result is valid.
// An 8-entry result queue with a credit count parts input from output.
// Reset (synchronous, active low): peaks cleared, queue empty,
//   range_db = 30, channel_count = 2.
module stereo_block_peak_db_meter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [31:0]                      s_axis_tdata,  // left_sample, right_sample
    input  logic                             s_axis_tlast,  // last_in_block
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [23:0]                      m_axis_tdata,  // left_level, right_level
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sbpm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]                       i_cfg_data
);
    import sbpm_pkg::*;

    logic [RANGE_W-1:0] r_range_db;
    logic [CHAN_W-1:0]  r_channel_count;
    logic               w_accept, w_stereo, w_room;
    t_lane_ctl          w_ctl_l, w_ctl_r;
    t_lane_out          w_lane_l, w_lane_r;
    t_result            w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_db      <= RANGE_DB_RST;
            r_channel_count <= CHANNEL_COUNT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RANGE_DB:      r_range_db      <= i_cfg_data[RANGE_W-1:0];
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    // count 0 behaves as mono, 3 as stereo
    assign w_stereo      = r_channel_count[1];
    assign s_axis_tready = w_room;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_ctl_l = '{vld: w_accept, last: s_axis_tlast, upd: 1'b1};
    assign w_ctl_r = '{vld: w_accept, last: s_axis_tlast, upd: w_stereo};

    sbpm_lane u_lane_l (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl_l),
        .i_sample   (s_axis_tdata[IN_W-1:0]),
        .i_range_db (r_range_db),
        .o_out      (w_lane_l)
    );

    sbpm_lane u_lane_r (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl_r),
        .i_sample   (s_axis_tdata[2*IN_W-1:IN_W]),
        .i_range_db (r_range_db),
        .o_out      (w_lane_r)
    );

    sbpm_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (w_accept && s_axis_tlast),
        .i_left        (w_lane_l),
        .i_right       (w_lane_r),
        .o_room        (w_room),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (w_result)
    );

    assign m_axis_tdata = w_result;

    // lanes run in lockstep
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lane_l.vld == w_lane_r.vld)
        else $error("lane results out of step");

    // a lane result comes only from an earlier accepted block-closing item
    a_lane_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lane_l.vld |-> $past(w_accept && s_axis_tlast, 6))
        else $error("lane result without a closing item");

    // credits run out only with results already queued
    a_no_room_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input held off with nothing to deliver");

endmodule
